[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

[rtl/core/cspmv_pkg.sv]
// Types and constants for the COO sparse matrix-vector multiplier.
`default_nettype none

package cspmv_pkg;

  localparam int ROW_W = 11;
  localparam int COL_W = 11;
  localparam int VAL_W = 32;
  localparam int SUM_W = 64;

  localparam int VECTOR_DEPTH_DEF = 2048;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = 2;
  localparam int FIFO_CW = 3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_ENTRY = 1'b1;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic                    command;
    logic [ROW_W-1:0]        row_index;
    logic [COL_W-1:0]        col_index;
    logic signed [VAL_W-1:0] entry_value;
    logic signed [VAL_W-1:0] vector_value;
    logic                    last_entry;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]        result_row;
    logic signed [SUM_W-1:0] row_sum;
    logic                    last_result;
  } out_item_t;

  typedef struct packed {
    logic      a_valid;
    out_item_t a;
    logic      b_valid;
    out_item_t b;
  } push_t;

endpackage

`default_nettype wire

[rtl/core/coo_sparse_matrix_vector_multiply.sv]
// COO sparse matrix times dense vector, Q16.16 in, saturating Q32.32 row sums out.
//
// Input channel (item_valid/item_ready/item): command 0 writes vector_value to
// element col_index of the vector store; command 1 is a matrix entry, rows in
// sorted order, last_entry on the final entry of a stream. Loads past the
// store depth are dropped; entries past it read zero.
// Output channel (result_valid/result_ready/result): one row sum per row run,
// emitted when the row changes and after the last entry (last_result set).
// Throughput: one item per cycle while the result queue has room, set by the
// single vector read port and the 32x32 multiply stage feeding the accumulator.
// A result enters the queue once the entry that closes it (the next row's
// entry, or the last entry) has passed the read and multiply stages, which
// hold while item_ready is low. A 4-deep result queue sits between the
// accumulator and the output; item_ready drops while fewer than two slots are
// free, so a stalled receiver holds the pipeline without loss. Loads produce no result.
// Reset clears the accumulator, current row and queue; the vector store keeps
// no reset value and must be loaded before use. No clearing pass is needed.
`default_nettype none

module coo_sparse_matrix_vector_multiply
  import cspmv_pkg::*;
#(
  parameter int VECTOR_DEPTH = VECTOR_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      item_valid,
  output logic           item_ready,
  input  wire in_item_t  item,
  output logic           result_valid,
  input  wire logic      result_ready,
  output out_item_t      result
);

  localparam int AW = $clog2(VECTOR_DEPTH);
  localparam int CW = (AW > COL_W) ? AW : COL_W;

  logic                    advance;
  logic                    accept;
  logic [CW:0]             col_ext;
  logic                    in_range;
  logic [AW-1:0]           addr;
  logic signed [VAL_W-1:0] rd_data;
  push_t                   push;
  logic                    room2;

  assign advance = room2;
  assign item_ready = advance;
  assign accept = item_valid && item_ready;

  assign col_ext = (CW + 1)'(item.col_index);
  assign in_range = (col_ext < (CW + 1)'(VECTOR_DEPTH));
  assign addr = col_ext[AW-1:0];

  cspmv_vec_mem #(
    .DEPTH(VECTOR_DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (accept && (item.command == CMD_LOAD) && in_range),
    .wr_addr(addr),
    .wr_data(item.vector_value),
    .rd_en  (advance),
    .rd_addr(addr),
    .rd_data(rd_data)
  );

  cspmv_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .entry_in   (accept && (item.command == CMD_ENTRY)),
    .row_in     (item.row_index),
    .value_in   (item.entry_value),
    .last_in    (item.last_entry),
    .in_range_in(in_range),
    .rd_data    (rd_data),
    .push       (push)
  );

  cspmv_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .room2       (room2),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

endmodule

`default_nettype wire

[rtl/core/cspmv_vec_mem.sv]
// Vector store: single-port-write, registered-read memory.
`default_nettype none

module cspmv_vec_mem
  import cspmv_pkg::*;
#(
  parameter int DEPTH = VECTOR_DEPTH_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  wire logic                    clk,
  input  wire logic                    wr_en,
  input  wire logic [AW-1:0]           wr_addr,
  input  wire logic signed [VAL_W-1:0] wr_data,
  input  wire logic                    rd_en,
  input  wire logic [AW-1:0]           rd_addr,
  output logic signed [VAL_W-1:0]      rd_data
);

  logic signed [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/cspmv_accum.sv]
// Multiply stage and saturating row accumulator.
`default_nettype none

module cspmv_accum
  import cspmv_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    advance,
  input  wire logic                    entry_in,
  input  wire logic [ROW_W-1:0]        row_in,
  input  wire logic signed [VAL_W-1:0] value_in,
  input  wire logic                    last_in,
  input  wire logic                    in_range_in,
  input  wire logic signed [VAL_W-1:0] rd_data,
  output push_t                        push
);

  // stage 1: aligned with the vector read data
  logic                    s1_valid;
  logic [ROW_W-1:0]        s1_row;
  logic signed [VAL_W-1:0] s1_value;
  logic                    s1_last;
  logic                    s1_in_range;

  // stage 2: product
  logic                    s2_valid;
  logic [ROW_W-1:0]        s2_row;
  logic                    s2_last;
  logic signed [SUM_W-1:0] s2_prod;

  // accumulator state
  logic signed [SUM_W-1:0] acc;
  logic [ROW_W-1:0]        cur_row;
  logic                    seen;

  logic signed [VAL_W-1:0] elem;
  logic signed [SUM_W-1:0] prod_next;
  logic                    row_change;
  logic signed [SUM_W-1:0] base;
  logic [SUM_W:0]          sum_wide;
  logic signed [SUM_W-1:0] sum;
  logic                    fire;

  assign elem = s1_in_range ? rd_data : '0;
  assign prod_next = s1_value * elem;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= entry_in;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_row <= row_in;
      s1_value <= value_in;
      s1_last <= last_in;
      s1_in_range <= in_range_in;
      s2_row <= s1_row;
      s2_last <= s1_last;
      s2_prod <= prod_next;
    end
  end

  assign fire = advance && s2_valid;
  assign row_change = seen && (s2_row != cur_row);
  assign base = row_change ? '0 : acc;
  assign sum_wide = {base[SUM_W-1], base} + {s2_prod[SUM_W-1], s2_prod};

  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum = sum_wide[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cur_row <= '0;
      seen <= 1'b0;
    end else if (fire) begin
      cur_row <= s2_row;
      if (s2_last) begin
        acc <= '0;
        seen <= 1'b0;
      end else begin
        acc <= sum;
        seen <= 1'b1;
      end
    end
  end

  always_comb begin
    push.a_valid = fire && row_change;
    push.a.result_row = cur_row;
    push.a.row_sum = acc;
    push.a.last_result = 1'b0;
    push.b_valid = fire && s2_last;
    push.b.result_row = s2_row;
    push.b.row_sum = sum;
    push.b.last_result = 1'b1;
  end

endmodule

`default_nettype wire

[rtl/core/cspmv_fifo.sv]
// Result queue taking up to two results per cycle, one out per cycle while result_ready is high.
`default_nettype none

module cspmv_fifo
  import cspmv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire push_t      push,
  output logic            room2,
  output logic            result_valid,
  input  wire logic       result_ready,
  output out_item_t       result
);

  out_item_t          slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;
  logic [FIFO_CW-1:0] count;
  logic [FIFO_AW-1:0] wptr_b;
  logic [FIFO_CW-1:0] n_push;
  logic               pop;

  assign pop = result_valid && result_ready;
  assign wptr_b = push.a_valid ? wptr + FIFO_AW'(1) : wptr;
  assign n_push = FIFO_CW'(push.a_valid) + FIFO_CW'(push.b_valid);

  assign result_valid = (count != '0);
  assign result = slots[rptr];
  assign room2 = (count <= FIFO_CW'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.a_valid) begin
      slots[wptr] <= push.a;
    end
    if (push.b_valid) begin
      slots[wptr_b] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      wptr <= wptr + n_push[FIFO_AW-1:0];
      if (pop) begin
        rptr <= rptr + FIFO_AW'(1);
      end
      count <= count + n_push - FIFO_CW'(pop);
    end
  end

endmodule

`default_nettype wire

[rtl/core/cspmv_checker.sv]
// Port-level checker for the sparse matrix-vector multiplier, with its bind.
`default_nettype none
`include "assert_macros.svh"

module cspmv_checker
  import cspmv_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      item_ready,
  input wire logic      result_valid,
  input wire logic      result_ready,
  input wire out_item_t result
);

  // queue empty and input open right after reset
  `ASSERT_CLK_ALWAYS(a_reset_clear, clk, rst |=> (item_ready && !result_valid))

  // input backpressure only while results wait
  `ASSERT_CLK(a_ready_needs_result, clk, rst, !item_ready |-> result_valid)

  // an offered result stays until its transfer
  `ASSERT_CLK(a_result_held, clk, rst, (result_valid && !result_ready) |=> result_valid)

  // and keeps its payload
  `ASSERT_CLK(a_result_stable, clk, rst, (result_valid && !result_ready) |=> $stable(result))

endmodule

bind coo_sparse_matrix_vector_multiply cspmv_checker u_cspmv_checker (.*);

`default_nettype wire

[dv/coo_sparse_matrix_vector_multiply_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the COO sparse matrix-vector multiplier.
module tb;
  import cspmv_pkg::*;

  localparam int DEPTH = VECTOR_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 900;
  localparam int CALM_AFTER = 780;
  localparam int QUIET_LIMIT = 2000;
  localparam out_item_t NO_SUM = '0;

  typedef struct {
    in_item_t  it;
    int        n;
    out_item_t a;
    out_item_t b;
  } plan_row_t;

  logic      clk;
  logic      rst;
  logic      item_valid;
  logic      item_ready;
  in_item_t  item;
  logic      result_valid;
  logic      result_ready;
  out_item_t result;

  coo_sparse_matrix_vector_multiply dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  // predictor state
  logic signed [VAL_W-1:0] vec_copy [0:DEPTH-1];
  bit                      loaded [0:DEPTH-1];
  int                      loaded_cols[$];
  logic signed [SUM_W-1:0] acc_copy;
  logic [ROW_W-1:0]        row_copy;
  bit                      row_open;

  out_item_t sums_due[$];
  plan_row_t plan[$];
  int        mismatches;
  int        sent;
  int        quiet;
  bit        calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_item_t ld(logic [COL_W-1:0] col, logic [VAL_W-1:0] v);
    in_item_t x;
    x.command      = CMD_LOAD;
    x.row_index    = ROW_W'($urandom);
    x.col_index    = col;
    x.entry_value  = $urandom;
    x.vector_value = v;
    x.last_entry   = 1'($urandom);
    return x;
  endfunction

  function automatic in_item_t en(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                  logic [VAL_W-1:0] v, logic last);
    in_item_t x;
    x.command      = CMD_ENTRY;
    x.row_index    = row;
    x.col_index    = col;
    x.entry_value  = v;
    x.vector_value = $urandom;
    x.last_entry   = last;
    return x;
  endfunction

  function automatic out_item_t sum_of(logic [ROW_W-1:0] row, logic [SUM_W-1:0] s,
                                       logic last);
    out_item_t r;
    r.result_row  = row;
    r.row_sum     = s;
    r.last_result = last;
    return r;
  endfunction

  function automatic void add_row(in_item_t x, int n, out_item_t a, out_item_t b);
    plan_row_t p;
    p.it = x;
    p.n  = n;
    p.a  = a;
    p.b  = b;
    plan.push_back(p);
  endfunction

  function automatic logic [VAL_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3, 4: return $urandom_range(0, 1) ? VAL_W'($urandom_range(0, 32'h3FFFF))
                                         : -VAL_W'($urandom_range(0, 32'h3FFFF));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [COL_W-1:0] pick_col();
    return COL_W'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]);
  endfunction

  // multiply-accumulate model: returns the row sums closed by one transfer
  task automatic mac_row_sums(input in_item_t x, output int n,
                              output out_item_t r0, output out_item_t r1);
    logic signed [SUM_W-1:0] prod;
    logic signed [SUM_W:0]   wide;
    n  = 0;
    r0 = NO_SUM;
    r1 = NO_SUM;
    if (x.command == CMD_LOAD) begin
      vec_copy[x.col_index] = x.vector_value;
      if (!loaded[x.col_index]) begin
        loaded[x.col_index] = 1'b1;
        loaded_cols.push_back(int'(x.col_index));
      end
    end else begin
      if (row_open && x.row_index != row_copy) begin
        r0 = sum_of(row_copy, acc_copy, 1'b0);
        n = 1;
        acc_copy = '0;
      end
      prod = $signed(x.entry_value) * $signed(vec_copy[x.col_index]);
      wide = $signed({acc_copy[SUM_W-1], acc_copy}) + $signed({prod[SUM_W-1], prod});
      if (wide[SUM_W] != wide[SUM_W-1])
        acc_copy = wide[SUM_W] ? SUM_MIN : SUM_MAX;
      else
        acc_copy = wide[SUM_W-1:0];
      row_copy = x.row_index;
      row_open = 1'b1;
      if (x.last_entry) begin
        if (n == 0) r0 = sum_of(row_copy, acc_copy, 1'b1);
        else r1 = sum_of(row_copy, acc_copy, 1'b1);
        n++;
        acc_copy = '0;
        row_open = 1'b0;
      end
    end
  endtask

  task automatic drive(input in_item_t x, input int pin_n, input out_item_t p0,
                       input out_item_t p1);
    int        n;
    out_item_t r0;
    out_item_t r1;
    item       <= x;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    mac_row_sums(x, n, r0, r1);
    if (pin_n >= 0) begin
      n  = pin_n;
      r0 = p0;
      r1 = p1;
    end
    if (n > 0) sums_due.push_back(r0);
    if (n > 1) sums_due.push_back(r1);
    sent++;
    calm = sent >= CALM_AFTER;
  endtask

  task automatic pause(input int cycles);
    item_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    if (sums_due.size() != 0) begin
      item_valid <= 1'b0;
      while (sums_due.size() != 0) @(posedge clk);
    end
  endtask

  task automatic step(input in_item_t x, input bit gaps_on);
    if (gaps_on && !calm && $urandom_range(0, 5) == 0) pause($urandom_range(1, 19));
    drive(x, -1, NO_SUM, NO_SUM);
  endtask

  // loads, then an entry stream of row runs, mostly in ascending row order, with some noise
  task automatic run_phase(input bit gaps_on);
    int               nld;
    int               nrow;
    int               nent;
    logic             last;
    logic [ROW_W-1:0] r;
    nld = $urandom_range(1, loaded_cols.size() < 64 ? 48 : 12);
    repeat (nld) step(ld(COL_W'($urandom_range(0, DEPTH - 1)), rand_word()), gaps_on);
    r = ROW_W'($urandom_range(0, DEPTH - 1));
    nrow = $urandom_range(1, 8);
    for (int i = 0; i < nrow; i++) begin
      nent = $urandom_range(1, 6);
      for (int j = 0; j < nent; j++) begin
        if ($urandom_range(0, 11) == 0)
          step(ld(COL_W'($urandom_range(0, DEPTH - 1)), rand_word()), gaps_on);
        if (i == nrow - 1 && j == nent - 1) last = $urandom_range(0, 7) != 0;
        else last = $urandom_range(0, 30) == 0;
        step(en(r, pick_col(), rand_word(), last), gaps_on);
      end
      case ($urandom_range(0, 9))
        0: r = ROW_W'($urandom_range(0, DEPTH - 1));
        1: r = r - ROW_W'($urandom_range(1, 3));
        default: r = r + ROW_W'($urandom_range(1, 3));
      endcase
    end
  endtask

  task automatic report_mismatch(input string what, input logic [SUM_W-1:0] got,
                                 input logic [SUM_W-1:0] want);
    $display("t=%0t %s: got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (sums_due.size() == 0) begin
        report_mismatch("unexpected result", result.row_sum, '0);
      end else begin
        if (result.result_row !== sums_due[0].result_row)
          report_mismatch("result_row", SUM_W'(result.result_row),
                          SUM_W'(sums_due[0].result_row));
        if (result.row_sum !== sums_due[0].row_sum)
          report_mismatch("row_sum", result.row_sum, sums_due[0].row_sum);
        if (result.last_result !== sums_due[0].last_result)
          report_mismatch("last_result", SUM_W'(result.last_result),
                          SUM_W'(sums_due[0].last_result));
        void'(sums_due.pop_front());
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    int hold;
    hold = 0;
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        result_ready <= 1'b0;
        hold = $urandom_range(1, 19) - 1;
      end else begin
        result_ready <= 1'b1;
        hold = $urandom_range(0, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("coo_sparse_matrix_vector_multiply: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    bit gaps_on;
    mismatches = 0;
    sent = 0;
    quiet = 0;
    calm = 1'b0;
    acc_copy = '0;
    row_copy = '0;
    row_open = 1'b0;
    foreach (loaded[i]) loaded[i] = 1'b0;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;

    add_row(ld(11'd0,    32'h0001_0000), 0, NO_SUM, NO_SUM);
    add_row(ld(11'd2047, 32'h7FFF_FFFF), 0, NO_SUM, NO_SUM);
    add_row(ld(11'd1,    32'h8000_0000), 0, NO_SUM, NO_SUM);
    add_row(ld(11'd5,    32'hFFFF_0000), 0, NO_SUM, NO_SUM);
    add_row(en(11'd0, 11'd0, 32'h0002_0000, 1'b0), 0, NO_SUM, NO_SUM);
    add_row(en(11'd0, 11'd5, 32'h0003_0000, 1'b1), 1,
            sum_of(11'd0, 64'hFFFF_FFFF_0000_0000, 1'b1), NO_SUM);
    // positive saturation, held while more is added
    add_row(en(11'd5, 11'd1, 32'h8000_0000, 1'b0), 0, NO_SUM, NO_SUM);
    add_row(en(11'd5, 11'd1, 32'h8000_0000, 1'b0), 0, NO_SUM, NO_SUM);
    add_row(en(11'd5, 11'd1, 32'h8000_0000, 1'b1), 1, sum_of(11'd5, SUM_MAX, 1'b1), NO_SUM);
    // negative saturation, closed by a row change
    add_row(en(11'd6, 11'd1, 32'h7FFF_FFFF, 1'b0), 0, NO_SUM, NO_SUM);
    add_row(en(11'd6, 11'd1, 32'h7FFF_FFFF, 1'b0), 0, NO_SUM, NO_SUM);
    add_row(en(11'd6, 11'd1, 32'h7FFF_FFFF, 1'b0), 0, NO_SUM, NO_SUM);
    add_row(en(11'd7, 11'd0, 32'h0001_0000, 1'b0), 1, sum_of(11'd6, SUM_MIN, 1'b0), NO_SUM);
    // load between entries
    add_row(ld(11'd0, 32'hFFFF_FFFF), 0, NO_SUM, NO_SUM);
    add_row(en(11'd7, 11'd0, 32'h0001_0000, 1'b0), -1, NO_SUM, NO_SUM);
    add_row(en(11'd2047, 11'd2047, 32'h7FFF_FFFF, 1'b0), -1, NO_SUM, NO_SUM);
    add_row(en(11'd2047, 11'd2047, 32'hFFFF_FFFF, 1'b1), -1, NO_SUM, NO_SUM);
    add_row(en(11'd0, 11'd0, 32'h0000_0000, 1'b1), 1, sum_of(11'd0, '0, 1'b1), NO_SUM);
    add_row(ld(11'd1023, 32'h0000_8000), 0, NO_SUM, NO_SUM);
    add_row(en(11'd1, 11'd1023, 32'hFFFF_FFFF, 1'b1), -1, NO_SUM, NO_SUM);
    // row change and last on the same transfer
    add_row(en(11'd3, 11'd2047, 32'h0000_0001, 1'b0), -1, NO_SUM, NO_SUM);
    add_row(en(11'd4, 11'd5, 32'h0001_0000, 1'b1), -1, NO_SUM, NO_SUM);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if ($urandom_range(0, 4) == 0) pause($urandom_range(1, 19));
      drive(plan[i].it, plan[i].n, plan[i].a, plan[i].b);
    end
    drain();

    while (sent < RANDOM_ITEMS) begin
      gaps_on = $urandom_range(0, 2) != 0;
      run_phase(gaps_on);
      if (!calm && $urandom_range(0, 5) == 0) drain();
    end

    item_valid <= 1'b0;
    while (sums_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0)
      $display("coo_sparse_matrix_vector_multiply: match");
    else
      $display("coo_sparse_matrix_vector_multiply: mismatch");
    $finish;
  end

endmodule

[coo_sparse_matrix_vector_multiply.f]
+incdir+rtl/core
rtl/core/cspmv_pkg.sv
rtl/core/cspmv_vec_mem.sv
rtl/core/cspmv_accum.sv
rtl/core/cspmv_fifo.sv
rtl/core/coo_sparse_matrix_vector_multiply.sv
rtl/core/cspmv_checker.sv
dv/coo_sparse_matrix_vector_multiply_tb.sv
